// File: design/rau_pkg.sv
package rau_pkg;

  // operand width: each operand is the low VW bits of its field
  localparam int VW = 32;

  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_SUB  = 3'd1;
  localparam logic [2:0] ACT_MUL  = 3'd2;
  localparam logic [2:0] ACT_DIV  = 3'd3;
  localparam logic [2:0] ACT_SIMP = 3'd4;

  localparam logic signed [64:0] SUM_HI = (65'sd1 <<< (2 * VW - 1)) - 65'sd1;
  localparam logic signed [64:0] SUM_LO = -SUM_HI - 65'sd1;
  localparam logic [31:0] QUO_HI = 32'((64'd1 << (VW - 1)) - 64'd1);

  typedef struct packed {
    logic [2:0]         act;
    logic               zero_err;
    logic signed [31:0] an;
    logic signed [31:0] ad;
    logic signed [31:0] bn;
    logic signed [31:0] bd;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dvd;
    logic [31:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic signed [31:0] sext_op(input logic [31:0] x);
    logic signed [31:0] t;
    t = $signed(x << (32 - VW));
    return t >>> (32 - VW);
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// File: design/rational_arithmetic_unit.sv
// Rational arithmetic on two signed fractions a = a_num/a_den, b = b_num/b_den.
// Input channel in_*: in_tuser carries the action (add, subtract, multiply,
// divide, simplify both), in_tdata the four operands. Each input beat gives
// exactly one result beat on out_*: tdata holds the result fraction and the
// second reduced fraction, tuser the error flag.
// Add, subtract, multiply and divide form three products through one 32x32
// multiplier, then the sum, saturated for add and subtract; a zero-divisor or
// unused-action beat goes straight to the output. Simplify runs Euclid on each
// fraction through a serial divider, one run per remainder or quotient.
// The front classifies beats into a two-entry queue, so up to two beats are
// taken while the back is busy; one item is worked at a time.
// Reset empties the queue and the output register. When the receiver stalls,
// the result holds in the output register and the back waits after finishing
// the next item; the queue then fills and in_tready drops.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  logic [2:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // res_num, res_den, second_num, second_den
  output logic         out_tuser   // error_flag
);

  logic  q_valid, q_pop;
  item_t q_item;

  rau_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .act(in_tuser), .data(in_tdata),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  rau_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(out_tdata), .out_err(out_tuser)
  );

endmodule

// File: design/rau_front.sv
module rau_front import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   act,
  input  logic [127:0] data,
  output logic         q_valid,
  input  logic         q_pop,
  output item_t        q_item
);

  item_t       cls;
  item_t       mem [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  // classify the incoming beat
  always_comb begin
    cls.act = act;
    cls.an  = sext_op(data[31:0]);
    cls.ad  = sext_op(data[63:32]);
    cls.bn  = sext_op(data[95:64]);
    cls.bd  = sext_op(data[127:96]);
    case (act)
      ACT_ADD, ACT_SUB: cls.zero_err = (cls.ad == 32'sd0) || (cls.bd == 32'sd0);
      ACT_DIV:          cls.zero_err = (cls.bn == 32'sd0);
      default:          cls.zero_err = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem[rp_r];

  // advance queue pointers
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= cls;
    end
  end

endmodule

// File: design/rau_div.sv
module rau_div import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] shf, trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    shf      = {rem_r[31:0], quo_r[31]};
    trial    = shf - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = 33'd0;
      quo_nxt  = req.dvd;
      dvs_nxt  = req.dvs;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shf;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r[31:0];

endmodule

// File: design/rau_back.sv
module rau_back import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  item_t         q_item,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [191:0]  out_data,
  output logic          out_err
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_GCHK  = 3'd3;
  localparam logic [2:0] S_GWAIT = 3'd4;
  localparam logic [2:0] S_QCHK  = 3'd5;
  localparam logic [2:0] S_QWAIT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                frac_r, frac_nxt, part_r, part_nxt;
  item_t               item_r, item_nxt;
  logic signed [31:0]  n_r, n_nxt, d_r, d_nxt, g_r, g_nxt, qn_r, qn_nxt;
  logic signed [63:0]  p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt, prod;
  logic signed [63:0]  rn_r, rn_nxt, rd_r, rd_nxt;
  logic signed [31:0]  sn_r, sn_nxt, sd_r, sd_nxt;
  logic                err_r, err_nxt;
  logic                ov_r, ov_nxt, load;
  logic [191:0]        od_r;
  logic                oe_r;
  logic signed [31:0]  ma, mb, xn, xd, xs, qs, rs, fin_n, fin_d;
  logic signed [64:0]  sum;
  logic                fin;
  div_req_t            dreq;
  div_rsp_t            drsp;

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign xn = frac_r ? item_r.bn : item_r.an;
  assign xd = frac_r ? item_r.bd : item_r.ad;
  assign xs = part_r ? xd : xn;

  // multiplier operand pairs per step
  always_comb begin
    case (cnt_r)
      2'd0:    begin ma = item_r.an; mb = (item_r.act == ACT_MUL) ? item_r.bn : item_r.bd; end
      2'd1:    begin ma = item_r.bn; mb = item_r.ad; end
      default: begin ma = item_r.ad; mb = (item_r.act == ACT_DIV) ? item_r.bn : item_r.bd; end
    endcase
    prod = ma * mb;
  end

  assign sum = (item_r.act == ACT_SUB) ? {p0_r[63], p0_r} - {p1_r[63], p1_r}
                                       : {p0_r[63], p0_r} + {p1_r[63], p1_r};

  // signed quotient and truncating remainder from the divider
  always_comb begin
    rs = n_r[31] ? -$signed(drsp.rem) : $signed(drsp.rem);
    if (xs[31] ^ g_r[31]) begin
      qs = -$signed(drsp.quo);
    end else if (drsp.quo > QUO_HI) begin
      qs = $signed(QUO_HI);
    end else begin
      qs = $signed(drsp.quo);
    end
  end

  assign load = (state_r == S_OUT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    frac_nxt  = frac_r;
    part_nxt  = part_r;
    item_nxt  = item_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    g_nxt     = g_r;
    qn_nxt    = qn_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    sn_nxt    = sn_r;
    sd_nxt    = sd_r;
    err_nxt   = err_r;
    q_pop     = 1'b0;
    fin       = 1'b0;
    fin_n     = xn;
    fin_d     = xd;
    dreq.start = 1'b0;
    dreq.dvd   = mag(n_r);
    dreq.dvs   = mag(d_r);
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          err_nxt  = 1'b0;
          rn_nxt   = 64'sd0;
          rd_nxt   = 64'sd0;
          sn_nxt   = 32'sd0;
          sd_nxt   = 32'sd0;
          cnt_nxt  = 2'd0;
          if (q_item.act > ACT_SIMP) begin
            err_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else if (q_item.zero_err) begin
            err_nxt   = 1'b1;
            rn_nxt    = 64'(q_item.an);
            rd_nxt    = 64'(q_item.ad);
            state_nxt = S_OUT;
          end else if (q_item.act == ACT_SIMP) begin
            frac_nxt  = 1'b0;
            n_nxt     = q_item.an;
            d_nxt     = q_item.ad;
            state_nxt = S_GCHK;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        case (cnt_r)
          2'd0:    p0_nxt = prod;
          2'd1:    p1_nxt = prod;
          default: p2_nxt = prod;
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        rd_nxt = p2_r;
        if (item_r.act == ACT_ADD || item_r.act == ACT_SUB) begin
          if (sum > SUM_HI) begin
            rn_nxt  = 64'(SUM_HI);
            err_nxt = 1'b1;
          end else if (sum < SUM_LO) begin
            rn_nxt  = 64'(SUM_LO);
            err_nxt = 1'b1;
          end else begin
            rn_nxt = sum[63:0];
          end
        end else begin
          rn_nxt = p0_r;
        end
        state_nxt = S_OUT;
      end
      S_GCHK: begin
        if (d_r == 32'sd0) begin
          g_nxt     = n_r;
          state_nxt = S_QCHK;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (drsp.done) begin
          n_nxt     = d_r;
          d_nxt     = rs;
          state_nxt = S_GCHK;
        end
      end
      S_QCHK: begin
        if (g_r == 32'sd0) begin
          err_nxt = 1'b1;
          fin     = 1'b1;
        end else begin
          dreq.start = 1'b1;
          dreq.dvd   = mag(xn);
          dreq.dvs   = mag(g_r);
          part_nxt   = 1'b0;
          state_nxt  = S_QWAIT;
        end
      end
      S_QWAIT: begin
        dreq.dvd = mag(xd);
        dreq.dvs = mag(g_r);
        if (drsp.done) begin
          if (!(xs[31] ^ g_r[31]) && drsp.quo > QUO_HI) begin
            err_nxt = 1'b1;
          end
          if (!part_r) begin
            qn_nxt     = qs;
            part_nxt   = 1'b1;
            dreq.start = 1'b1;
          end else begin
            fin   = 1'b1;
            fin_n = qn_r;
            fin_d = qs;
          end
        end
      end
      default: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
    // store one reduced fraction, then move to the next or to the output
    if (fin) begin
      if (!frac_r) begin
        rn_nxt    = 64'(fin_n);
        rd_nxt    = 64'(fin_d);
        frac_nxt  = 1'b1;
        n_nxt     = item_r.bn;
        d_nxt     = item_r.bd;
        state_nxt = S_GCHK;
      end else begin
        sn_nxt    = fin_n;
        sd_nxt    = fin_d;
        state_nxt = S_OUT;
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= 2'd0;
      frac_r  <= 1'b0;
      part_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      frac_r  <= frac_nxt;
      part_r  <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    g_r    <= g_nxt;
    qn_r   <= qn_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    rn_r   <= rn_nxt;
    rd_r   <= rd_nxt;
    sn_r   <= sn_nxt;
    sd_r   <= sd_nxt;
    err_r  <= err_nxt;
    if (load) begin
      od_r <= {sd_r, sn_r, rd_r, rn_r};
      oe_r <= err_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_err   = oe_r;

endmodule

// File: dv/tb_top.sv
module tb_top;
  import rau_pkg::*;

  typedef struct {
    logic signed [63:0] rn;
    logic signed [63:0] rd;
    logic signed [31:0] sn;
    logic signed [31:0] sd;
    logic               err;
  } frac_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic         out_tuser;

  frac_res_t pending_q[$];
  int        fail_cnt = 0;
  bit        stall_en = 1'b1;

  rational_arithmetic_unit uut (.*);

  always #10 clk = ~clk;

  // operand taken as the low VW bits, two's complement
  function automatic longint op_val(logic [31:0] x);
    logic [31:0] m;
    m = x << (32 - VW);
    return longint'($signed(m)) >>> (32 - VW);
  endfunction

  function automatic longint gcd_trunc(longint n, longint d);
    longint r;
    while (d != 0) begin
      r = n % d;
      n = d;
      d = r;
    end
    return n;
  endfunction

  // reduce one fraction by its truncating-remainder gcd, saturate the quotient
  function automatic void reduce_frac(inout longint n, inout longint d, inout logic err);
    longint g, hi, q;
    hi = (64'sd1 <<< (VW - 1)) - 1;
    g = gcd_trunc(n, d);
    if (g == 0) begin
      err = 1'b1;
      return;
    end
    q = (n == -64'sd9223372036854775807 - 1) ? n : n / g;
    if (q > hi) begin err = 1'b1; q = hi; end
    n = q;
    q = d / g;
    if (q > hi) begin err = 1'b1; q = hi; end
    d = q;
  endfunction

  function automatic frac_res_t rational_calc(logic [2:0] act, logic [31:0] xa, logic [31:0] xb,
                                             logic [31:0] xc, logic [31:0] xd);
    frac_res_t r;
    longint an, ad, bn, bd, t, p, hi, lo, rn, rd, sn, sd;
    logic e;
    an = op_val(xa); ad = op_val(xb); bn = op_val(xc); bd = op_val(xd);
    hi = longint'(SUM_HI[63:0]);
    lo = -hi - 1;
    rn = 0; rd = 0; sn = 0; sd = 0; e = 1'b0;
    case (act)
      ACT_ADD, ACT_SUB: begin
        if (ad == 0 || bd == 0) begin
          e = 1'b1; rn = an; rd = ad;
        end else begin
          t = bn * ad;
          if (act == ACT_SUB) t = -t;
          p = an * bd;
          rd = ad * bd;
          if (t > 0 && p > hi - t) begin e = 1'b1; rn = hi; end
          else if (t < 0 && p < lo - t) begin e = 1'b1; rn = lo; end
          else rn = p + t;
        end
      end
      ACT_MUL: begin
        rn = an * bn; rd = ad * bd;
      end
      ACT_DIV: begin
        if (bn == 0) begin
          e = 1'b1; rn = an; rd = ad;
        end else begin
          rn = an * bd; rd = ad * bn;
        end
      end
      ACT_SIMP: begin
        rn = an; rd = ad; sn = bn; sd = bd;
        reduce_frac(rn, rd, e);
        reduce_frac(sn, sd, e);
      end
      default: e = 1'b1;
    endcase
    r.rn = rn; r.rd = rd; r.sn = sn[31:0]; r.sd = sd[31:0]; r.err = e;
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one beat; predict on acceptance; valid stays up when the next
  // beat follows at once
  task automatic send_beat(logic [2:0] act, logic [31:0] xa, logic [31:0] xb,
                           logic [31:0] xc, logic [31:0] xd, bit idle = 1'b1);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {xd, xc, xb, xa};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(rational_calc(act, xa, xb, xc, xd));
    @(negedge clk);
  endtask

  // random stall on the result side
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_en) begin
        g = gap_len();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    frac_res_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat");
        fail_cnt++;
      end else begin
        x = pending_q.pop_front();
        if (out_tdata[63:0] !== x.rn) begin
          $error("res_num exp %0d got %0d", x.rn, $signed(out_tdata[63:0])); fail_cnt++;
        end
        if (out_tdata[127:64] !== x.rd) begin
          $error("res_den exp %0d got %0d", x.rd, $signed(out_tdata[127:64])); fail_cnt++;
        end
        if (out_tdata[159:128] !== x.sn) begin
          $error("second_num exp %0d got %0d", x.sn, $signed(out_tdata[159:128]));
          fail_cnt++;
        end
        if (out_tdata[191:160] !== x.sd) begin
          $error("second_den exp %0d got %0d", x.sd, $signed(out_tdata[191:160]));
          fail_cnt++;
        end
        if (out_tuser !== x.err) begin
          $error("error_flag exp %0b got %0b", x.err, out_tuser); fail_cnt++;
        end
      end
    end
  end

  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] NEG1 = 32'hffff_ffff;

  task automatic test_extremes();
    send_beat(ACT_ADD, MAXP, 32'd1, MAXP, 32'd1);
    send_beat(ACT_ADD, MINN, MINN, MINN, MINN);
    send_beat(ACT_SUB, MINN, MINN, MAXP, MINN);
    send_beat(ACT_SUB, MAXP, MINN, MINN, MINN);
    send_beat(ACT_MUL, MINN, MINN, MINN, MINN);
    send_beat(ACT_MUL, MAXP, 32'd0, NEG1, 32'd0);
    send_beat(ACT_DIV, MINN, MAXP, MINN, NEG1);
    send_beat(ACT_DIV, 32'd7, 32'd3, 32'd2, 32'd5);
  endtask

  task automatic test_error_cases();
    send_beat(ACT_ADD, 32'd5, 32'd0, 32'd3, 32'd4);
    send_beat(ACT_SUB, 32'd5, 32'd2, 32'd3, 32'd0);
    send_beat(ACT_DIV, 32'd5, 32'd2, 32'd0, 32'd9);
    send_beat(ACT_SIMP, 32'd0, 32'd0, 32'd6, 32'd4);
    send_beat(ACT_SIMP, MINN, NEG1, 32'd0, 32'd0);
    send_beat(3'd5, MAXP, MAXP, MAXP, MAXP);
    send_beat(3'd6, 32'd1, 32'd1, 32'd1, 32'd1);
    send_beat(3'd7, MINN, MINN, MINN, MINN);
  endtask

  task automatic test_simplify();
    send_beat(ACT_SIMP, 32'd12, 32'd18, 32'hfffffff6, 32'd4);
    send_beat(ACT_SIMP, 32'd5, 32'hfffffff6, 32'd0, 32'd7);
    send_beat(ACT_SIMP, 32'd9, 32'd0, MINN, MINN);
    send_beat(ACT_SIMP, MAXP, MINN, 32'd1, NEG1);
  endtask

  function automatic logic [31:0] rand_op();
    case ($urandom_range(0, 5))
      0: return MAXP;
      1: return MINN;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // simplify is slow: keep it to a small share, mostly small operands
  task automatic test_random(int n);
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(0, 99) < 8) ? ACT_SIMP :
            ($urandom_range(0, 49) == 0) ? 3'($urandom_range(5, 7)) :
            3'($urandom_range(0, 3));
      if (act == ACT_SIMP && $urandom_range(0, 3) != 0)
        send_beat(act, $urandom_range(0, 5000), $urandom_range(0, 5000),
                  -$urandom_range(0, 5000), $urandom_range(0, 5000));
      else
        send_beat(act, rand_op(), rand_op(), rand_op(), rand_op());
    end
  endtask

  task automatic test_back_to_back(int n);
    stall_en = 1'b0;
    for (int i = 0; i < n; i++)
      send_beat(3'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, 1'b0);
    stall_en = 1'b1;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_error_cases();
    test_simplify();
    test_back_to_back(100);
    test_random(1700);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #(20 * 5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
